### hw/rtl/mp3s2_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mp3s2_pkg: shared definitions for the 3x3 stride-2 max pool
// Size defaults, register indexes, register reset values and the result
// entry type used by the output queue.
// ----------------------------------------------------------------------------
package mp3s2_pkg;

   localparam int MAX_WIDTH_DEFAULT  = 256;
   localparam int MAX_HEIGHT_DEFAULT = 1024;

   localparam int IMAGE_WIDTH_BITS  = 9;
   localparam int IMAGE_HEIGHT_BITS = 11;
   localparam int CSR_DATA_BITS     = 11;
   localparam int CSR_INDEX_BITS    = 1;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_IMAGE_WIDTH  = 1'b0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_IMAGE_HEIGHT = 1'b1;

   localparam logic [IMAGE_WIDTH_BITS-1:0]  IMAGE_WIDTH_RESET  = 9'd129;
   localparam logic [IMAGE_HEIGHT_BITS-1:0] IMAGE_HEIGHT_RESET = 11'd97;

   // Output queue depth; three entries cover the two-stage pipeline.
   localparam int          RSP_QUEUE_DEPTH = 3;
   localparam logic [1:0]  RSP_QUEUE_LAST  = 2'd2;

   typedef struct packed {
      logic [7:0] pixel;
      logic       row_end;
      logic       frame_end;
   } rsp_entry_type;

endpackage

### hw/rtl/max_pool_3x3_stride2_u8_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// max_pool_3x3_stride2_u8_top: 3x3 max pool, stride 2, 8-bit pixels
// Streaming max pool with clamp-to-edge borders and a single line store.
// ----------------------------------------------------------------------------
// Usage:
//   Pixels enter in raster order on the req_ stream, one item per pixel, with
//   req_tuser set on the first pixel of a frame to clear the position
//   counters. Each output (ox, oy) is the maximum over input rows 2oy-1..2oy+1
//   and columns 2ox-1..2ox+1, clamped into the image, so a frame gives
//   ceil(W/2) x ceil(H/2) results on the rsp_ stream. rsp_tlast marks the
//   last result of an output row and rsp_tuser the last result of the frame.
//   Image width and height are written through the csr_ port; the user must
//   write them only while the block is idle, which the block does not enforce.
//   Zero acts as one and values above the maximum saturate. An accepted pixel
//   passes stage 1 and the output queue before its result is offered.
//   Throughput is one pixel per cycle while the output queue has room: the
//   line store is read in the accept cycle and written back in the next one,
//   and a write colliding with the next read of the same entry is forwarded.
//   A three-entry output queue decouples the receiver; when it stalls, the
//   queue fills and req_tready drops until there is room for the pixels in
//   flight, so nothing is lost.
//   Reset clears the counters, the running maximum and the queue, and loads
//   a 129 x 97 image size. The line store needs no clearing pass.
// ----------------------------------------------------------------------------
module max_pool_3x3_stride2_u8_top
   import mp3s2_pkg::*;
#(
   parameter int MAX_WIDTH  = MAX_WIDTH_DEFAULT,
   parameter int MAX_HEIGHT = MAX_HEIGHT_DEFAULT
) (
   input  logic                      clock,
   input  logic                      reset,
   // Pixel stream in
   input  logic                      req_tvalid,
   output logic                      req_tready,
   input  logic [7:0]                req_tdata,   // [7:0] pixel_in
   input  logic                      req_tuser,   // [0] frame_start
   // Result stream out
   output logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   output logic [7:0]                rsp_tdata,   // [7:0] pixel_out
   output logic                      rsp_tlast,   // row_end
   output logic                      rsp_tuser,   // [0] frame_end
   // Register write port
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CSR_DATA_BITS-1:0]  csr_data
);

   // Column counter is at least two bits so that the entry index is never empty.
   localparam int CW = ($clog2(MAX_WIDTH) > 2) ? $clog2(MAX_WIDTH) : 2;
   localparam int RW = $clog2(MAX_HEIGHT);
   localparam int AW = CW - 1;
   localparam int LINE_DEPTH = (MAX_WIDTH + 1) / 2;
   // Comparison widths hold both the register value and the saturation limit.
   localparam int WW = ($clog2(MAX_WIDTH + 1) > IMAGE_WIDTH_BITS) ?
                       $clog2(MAX_WIDTH + 1) : IMAGE_WIDTH_BITS;
   localparam int HW = ($clog2(MAX_HEIGHT + 1) > IMAGE_HEIGHT_BITS) ?
                       $clog2(MAX_HEIGHT + 1) : IMAGE_HEIGHT_BITS;

   // ---------------------------------------------------------------- registers
   logic [IMAGE_WIDTH_BITS-1:0]  image_width_ff;
   logic [IMAGE_HEIGHT_BITS-1:0] image_height_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         image_width_ff  <= IMAGE_WIDTH_RESET;
         image_height_ff <= IMAGE_HEIGHT_RESET;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_IMAGE_WIDTH: begin
               image_width_ff <= csr_data[IMAGE_WIDTH_BITS-1:0];
            end
            CSR_IMAGE_HEIGHT: begin
               image_height_ff <= csr_data[IMAGE_HEIGHT_BITS-1:0];
            end
         endcase
      end
   end

   // Effective sizes: zero acts as one, large values saturate.
   logic [WW-1:0] width_ext;
   logic [WW-1:0] width_eff;
   logic [HW-1:0] height_ext;
   logic [HW-1:0] height_eff;

   always_comb begin
      width_ext  = WW'(image_width_ff);
      height_ext = HW'(image_height_ff);
      priority if (width_ext == '0) begin
         width_eff = WW'(1);
      end else if (width_ext > WW'(MAX_WIDTH)) begin
         width_eff = WW'(MAX_WIDTH);
      end else begin
         width_eff = width_ext;
      end
      priority if (height_ext == '0) begin
         height_eff = HW'(1);
      end else if (height_ext > HW'(MAX_HEIGHT)) begin
         height_eff = HW'(MAX_HEIGHT);
      end else begin
         height_eff = height_ext;
      end
   end

   // ------------------------------------------------------------ accept stage
   logic          accept;
   logic [CW-1:0] col_ff;
   logic [CW-1:0] col_in;
   logic [RW-1:0] row_ff;
   logic [RW-1:0] row_in;
   logic [7:0]    hrun_ff;
   logic [7:0]    hrun_in;
   logic [CW-1:0] x;
   logic [RW-1:0] y;
   logic          last_col;
   logic          last_row;
   logic          have_col;
   logic [7:0]    colmax;
   logic [7:0]    hnew;
   logic [AW-1:0] ox;

   // Stage 1: the line store read is in flight for this item.
   logic          s1_valid_ff;
   logic          s1_have_col_ff;
   logic          s1_row_odd_ff;
   logic          s1_row_zero_ff;
   logic          s1_last_row_ff;
   logic          s1_last_col_ff;
   logic [7:0]    s1_colmax_ff;
   logic [AW-1:0] s1_addr_ff;
   logic          fwd_ff;
   logic [7:0]    fwd_data_ff;
   logic [7:0]    mem_rd_ff;
   logic [7:0]    line_mem [LINE_DEPTH];

   logic [7:0]    s1_vp;
   logic [7:0]    s1_wdata;
   logic [7:0]    s1_result;
   logic          s1_emit;

   // Output queue.
   rsp_entry_type q_mem [RSP_QUEUE_DEPTH];
   logic [1:0]    q_head_ff;
   logic [1:0]    q_tail_ff;
   logic [1:0]    q_count_ff;
   logic          q_push;
   logic          q_pop;

   // Room is needed for the queued results plus the item in stage 1.
   assign req_tready = (3'(q_count_ff) + 3'(s1_valid_ff)) < 3'(RSP_QUEUE_DEPTH);
   assign accept     = req_tvalid && req_tready;

   always_comb begin
      x        = req_tuser ? '0 : col_ff;
      y        = req_tuser ? '0 : row_ff;
      last_col = ((WW'(x) + WW'(1)) >= width_eff);
      last_row = ((HW'(y) + HW'(1)) >= height_eff);
      ox       = x[CW-1:1];
      hnew     = (x == '0) ? req_tdata :
                 ((hrun_ff > req_tdata) ? hrun_ff : req_tdata);
      colmax   = 8'd0;
      have_col = 1'b0;
      if (x[0]) begin
         // Odd column closes the triple 2ox-1 .. 2ox+1.
         colmax   = (hrun_ff > req_tdata) ? hrun_ff : req_tdata;
         hrun_in  = req_tdata;
         have_col = 1'b1;
      end else begin
         hrun_in = hnew;
         if (last_col) begin
            colmax   = hnew;
            have_col = 1'b1;
         end
      end
      if (last_col) begin
         col_in = '0;
         row_in = last_row ? '0 : (y + RW'(1));
      end else begin
         col_in = x + CW'(1);
         row_in = y;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff      <= '0;
         row_ff      <= '0;
         hrun_ff     <= '0;
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= accept;
         if (accept) begin
            col_ff  <= col_in;
            row_ff  <= row_in;
            hrun_ff <= hrun_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_have_col_ff <= have_col;
         s1_row_odd_ff  <= y[0];
         s1_row_zero_ff <= (y == '0);
         s1_last_row_ff <= last_row;
         s1_last_col_ff <= last_col;
         s1_colmax_ff   <= colmax;
         s1_addr_ff     <= ox;
         // The write of stage 1 lands at this same edge; forward it.
         fwd_ff         <= s1_valid_ff && s1_have_col_ff && (s1_addr_ff == ox);
         fwd_data_ff    <= s1_wdata;
      end
   end

   // Line store: read at accept, written back from stage 1.
   always_ff @(posedge clock) begin
      if (accept) begin
         mem_rd_ff <= line_mem[ox];
      end
      if (s1_valid_ff && s1_have_col_ff) begin
         line_mem[s1_addr_ff] <= s1_wdata;
      end
   end

   // ---------------------------------------------------------- vertical stage
   always_comb begin
      s1_vp = fwd_ff ? fwd_data_ff : mem_rd_ff;
      if (s1_row_odd_ff) begin
         // Odd row finishes the window begun on the row above.
         s1_result = (s1_vp > s1_colmax_ff) ? s1_vp : s1_colmax_ff;
         s1_wdata  = s1_colmax_ff;
         s1_emit   = s1_have_col_ff;
      end else begin
         s1_wdata  = s1_row_zero_ff ? s1_colmax_ff :
                     ((s1_vp > s1_colmax_ff) ? s1_vp : s1_colmax_ff);
         s1_result = s1_wdata;
         s1_emit   = s1_have_col_ff && s1_last_row_ff;
      end
   end

   // ------------------------------------------------------------ output queue
   assign q_push = s1_valid_ff && s1_emit;
   assign q_pop  = rsp_tvalid && rsp_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         q_head_ff  <= '0;
         q_tail_ff  <= '0;
         q_count_ff <= '0;
      end else begin
         if (q_push) begin
            q_tail_ff <= (q_tail_ff == RSP_QUEUE_LAST) ? 2'd0 : (q_tail_ff + 2'd1);
         end
         if (q_pop) begin
            q_head_ff <= (q_head_ff == RSP_QUEUE_LAST) ? 2'd0 : (q_head_ff + 2'd1);
         end
         q_count_ff <= q_count_ff + 2'(q_push) - 2'(q_pop);
      end
   end

   always_ff @(posedge clock) begin
      if (q_push) begin
         q_mem[q_tail_ff] <= '{pixel: s1_result,
                                row_end: s1_last_col_ff,
                                frame_end: s1_last_col_ff && s1_last_row_ff};
      end
   end

   assign rsp_tvalid = (q_count_ff != 2'd0);
   assign rsp_tdata  = q_mem[q_head_ff].pixel;
   assign rsp_tlast  = q_mem[q_head_ff].row_end;
   assign rsp_tuser  = q_mem[q_head_ff].frame_end;

`ifndef ASSERT_OFF
   // The queue never takes a result it has no room for.
   assert property (@(posedge clock) disable iff (reset)
      (q_push && !q_pop) |-> (q_count_ff < 2'(RSP_QUEUE_DEPTH)))
      else $error("output queue overflow");

   // Forwarding only ever serves the item that follows a line store write.
   assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && fwd_ff) |-> $past(s1_valid_ff && s1_have_col_ff))
      else $error("forward without a preceding write");

   // Stage 1 holds an item in the cycle after an accept.
   assert property (@(posedge clock) disable iff (reset)
      accept |=> s1_valid_ff)
      else $error("accepted item missing from stage 1");

   // The column position stays inside the line store range.
   assert property (@(posedge clock) disable iff (reset)
      (32'(col_ff) < 32'(MAX_WIDTH)))
      else $error("column counter beyond maximum width");
`endif

endmodule

### test/max_pool_3x3_stride2_u8_top_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// max_pool_3x3_stride2_u8_top_test: self-checking bench for the stride-2 pool
// Pixels are streamed into the block under a series of image sizes, and every
// pooled result is compared as it leaves the block with a bench-held behavioural
// model of the clamped 3x3 window, or a typed row's result. A short directed table
// comes first, followed by randomised frames, stalls and back-pressure.
// ----------------------------------------------------------------------------
module max_pool_3x3_stride2_u8_top_test;
   import mp3s2_pkg::*;

   // Sizes seen by the block; anything written above these saturates.
   localparam int WIDTH_CAP  = MAX_WIDTH_DEFAULT;
   localparam int HEIGHT_CAP = MAX_HEIGHT_DEFAULT;
   localparam int LINE_SLOTS = (WIDTH_CAP + 1) / 2;

   localparam int ITEM_TARGET   = 1950;
   // A result trails its pixel through stage 1 and the queue, so extra cycles
   // cover pixels still in flight.
   localparam int SETTLE_CYCLES = 4;
   localparam int TAIL_CYCLES   = 12;
   localparam int HOLD_CYCLES   = 120;
   localparam int REPORT_LIMIT  = 40;
   localparam int CALM_FROM     = 900;
   localparam int CALM_TO       = 1250;
   localparam time RUN_LIMIT_NS = 2_000_000;

   typedef enum logic [1:0] {
      SEND_PIXEL,
      SET_WIDTH,
      SET_HEIGHT
   } step_kind_type;

   // One row of the directed table. For a pixel row the low byte of value is
   // the pixel; for a register row value is the write data. Rows marked typed
   // carry their result, which stands in place of the model's prediction.
   typedef struct packed {
      step_kind_type kind;
      logic [10:0]   value;
      logic          first;
      logic          typed;
      logic          typed_emit;
      logic [7:0]    typed_pixel;
      logic          typed_row_end;
      logic          typed_frame_end;
   } opening_step_type;

   localparam int OPENING_STEPS = 32;

   // ----------------------------------------------------------------------
   // Block ports. Every input starts from a known value.
   // ----------------------------------------------------------------------
   logic                      clock      = 1'b0;
   logic                      reset      = 1'b1;
   logic                      req_tvalid = 1'b0;
   logic                      req_tready;
   logic [7:0]                req_tdata  = 8'h00;
   logic                      req_tuser  = 1'b0;
   logic                      rsp_tvalid;
   logic                      rsp_tready = 1'b0;
   logic [7:0]                rsp_tdata;
   logic                      rsp_tlast;
   logic                      rsp_tuser;
   logic                      csr_valid  = 1'b0;
   logic                      csr_ready;
   logic [CSR_INDEX_BITS-1:0] csr_index  = CSR_IMAGE_WIDTH;
   logic [CSR_DATA_BITS-1:0]  csr_data   = '0;

   // ----------------------------------------------------------------------
   // Bench state
   // ----------------------------------------------------------------------
   // Pooled results still owed by the block, oldest first.
   rsp_entry_type awaited_maxima [$];
   int mismatch_count   = 0;
   int pixels_accepted  = 0;
   int maxima_received  = 0;
   // Raised by the sender for a stretch with no idling on either side.
   logic quiet          = 1'b0;
   // Toggled by the sender to ask the receiver for one long hold-off.
   logic stall_cue      = 1'b0;

   // Model state: register copies, line store, position and running maximum.
   logic [IMAGE_WIDTH_BITS-1:0]  cfg_width  = IMAGE_WIDTH_RESET;
   logic [IMAGE_HEIGHT_BITS-1:0] cfg_height = IMAGE_HEIGHT_RESET;
   logic [7:0] line_max [LINE_SLOTS];
   logic [7:0] col_pos  = '0;
   logic [9:0] row_pos  = '0;
   logic [7:0] run_max  = '0;

   opening_step_type opening [OPENING_STEPS] = '{
      // After reset the image is 129 wide, so the first column yields nothing.
      '{SEND_PIXEL, 11'h07F, 1'b0, 1'b1, 1'b0, 8'h00, 1'b0, 1'b0},
      // A 1 x 1 image: every pixel is its own window and ends row and frame.
      '{SET_WIDTH,  11'd1,   1'b0, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0},
      '{SET_HEIGHT, 11'd1,   1'b0, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0},
      '{SEND_PIXEL, 11'h000, 1'b1, 1'b1, 1'b1, 8'h00, 1'b1, 1'b1},
      '{SEND_PIXEL, 11'h0FF, 1'b0, 1'b1, 1'b1, 8'hFF, 1'b1, 1'b1},
      '{SEND_PIXEL, 11'h0A5, 1'b0, 1'b1, 1'b1, 8'hA5, 1'b1, 1'b1},
      '{SEND_PIXEL, 11'h05A, 1'b1, 1'b1, 1'b1, 8'h5A, 1'b1, 1'b1},
      // Zero sizes behave as one.
      '{SET_WIDTH,  11'd0,   1'b0, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0},
      '{SET_HEIGHT, 11'd0,   1'b0, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0},
      '{SEND_PIXEL, 11'h03C, 1'b0, 1'b1, 1'b1, 8'h3C, 1'b1, 1'b1},
      // A 3 x 3 image gives 2 x 2 results with the borders repeated.
      '{SET_WIDTH,  11'd3,   1'b0, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0},
      '{SET_HEIGHT, 11'd3,   1'b0, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0},
      '{SEND_PIXEL, 11'h00A, 1'b1, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0},
      '{SEND_PIXEL, 11'h0C8, 1'b0, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0},
      '{SEND_PIXEL, 11'h01E, 1'b0, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0},
      '{SEND_PIXEL, 11'h028, 1'b0, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0},
      '{SEND_PIXEL, 11'h032, 1'b0, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0},
      '{SEND_PIXEL, 11'h03C, 1'b0, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0},
      '{SEND_PIXEL, 11'h0FF, 1'b0, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0},
      '{SEND_PIXEL, 11'h000, 1'b0, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0},
      '{SEND_PIXEL, 11'h05A, 1'b0, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0},
      // A 2 x 2 image: one result over all four pixels.
      '{SET_WIDTH,  11'd2,   1'b0, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0},
      '{SET_HEIGHT, 11'd2,   1'b0, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0},
      '{SEND_PIXEL, 11'h011, 1'b1, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0},
      '{SEND_PIXEL, 11'h080, 1'b0, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0},
      '{SEND_PIXEL, 11'h001, 1'b0, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0},
      '{SEND_PIXEL, 11'h07E, 1'b0, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0},
      // All-ones data: both sizes saturate to their maxima.
      '{SET_WIDTH,  11'h7FF, 1'b0, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0},
      '{SET_HEIGHT, 11'h7FF, 1'b0, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0},
      '{SEND_PIXEL, 11'h000, 1'b1, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0},
      '{SEND_PIXEL, 11'h0FF, 1'b0, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0},
      '{SEND_PIXEL, 11'h080, 1'b0, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0}
   };

   max_pool_3x3_stride2_u8_top DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always #2 clock = ~clock;

   // ----------------------------------------------------------------------
   // Behavioural model of the pool
   // ----------------------------------------------------------------------
   // A size of zero acts as one, and anything above the cap is the cap.
   function automatic int fit_size(input int raw, input int cap);
      if (raw == 0) return 1;
      if (raw > cap) return cap;
      return raw;
   endfunction

   function automatic logic [7:0] brighter(input logic [7:0] a, input logic [7:0] b);
      return (a > b) ? a : b;
   endfunction

   // Takes one pixel into the model and says whether it completes a window,
   // and if so what the block should send out for it.
   task automatic predict_window_max(input logic [7:0] pix, input logic first,
                                     output bit emit, output rsp_entry_type res);
      int         w;
      int         h;
      int         x;
      int         y;
      int         ox;
      bit         last_col;
      bit         last_row;
      bit         have_col;
      logic [7:0] col_max;
      w        = fit_size(int'(cfg_width), WIDTH_CAP);
      h        = fit_size(int'(cfg_height), HEIGHT_CAP);
      emit     = 1'b0;
      have_col = 1'b0;
      col_max  = '0;
      res      = '0;
      if (first) begin
         col_pos = '0;
         row_pos = '0;
      end
      x        = int'(col_pos);
      y        = int'(row_pos);
      last_col = (x + 1 >= w);
      last_row = (y + 1 >= h);
      ox       = x >> 1;
      if (ox >= LINE_SLOTS) ox = LINE_SLOTS - 1;

      // Odd columns close a triple; the last column closes a clamped one.
      if (x % 2 == 1) begin
         col_max  = brighter(run_max, pix);
         run_max  = pix;
         have_col = 1'b1;
      end else begin
         run_max = (x == 0) ? pix : brighter(run_max, pix);
         if (last_col) begin
            col_max  = run_max;
            have_col = 1'b1;
         end
      end

      // Odd rows finish a window using the partial from the row above; even
      // rows build a partial, and the bottom row finishes one on its own.
      if (have_col) begin
         if (y % 2 == 1) begin
            res.pixel    = brighter(line_max[ox], col_max);
            line_max[ox] = col_max;
            emit         = 1'b1;
         end else begin
            if (y != 0) col_max = brighter(line_max[ox], col_max);
            line_max[ox] = col_max;
            if (last_row) begin
               res.pixel = col_max;
               emit      = 1'b1;
            end
         end
      end

      if (last_col) begin
         col_pos = '0;
         row_pos = last_row ? 10'd0 : 10'(y + 1);
      end else begin
         col_pos = 8'(x + 1);
      end
      res.row_end   = last_col;
      res.frame_end = last_col && last_row;
   endtask

   // ----------------------------------------------------------------------
   // Sender side
   // ----------------------------------------------------------------------
   // Offers one pixel, after random idling outside the calm stretch, and records the
   // result it should cause once the block has taken it.
   task automatic offer_pixel(input logic [7:0] pix, input logic first, input bit typed,
                              input bit typed_emit, input rsp_entry_type typed_res);
      bit            emit;
      rsp_entry_type res;
      bit            calm;
      calm = (pixels_accepted >= CALM_FROM) && (pixels_accepted < CALM_TO);
      quiet <= calm;
      while (!calm && $urandom_range(0, 99) < 34) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= pix;
      req_tuser  <= first;
      do @(posedge clock); while (!req_tready);
      predict_window_max(pix, first, emit, res);
      if (typed) begin
         emit = typed_emit;
         res  = typed_res;
      end
      if (emit) awaited_maxima.push_back(res);
      pixels_accepted++;
   endtask

   // Stops offering pixels and waits until the block has nothing left to do.
   // Pixels that complete no window leave nothing to wait on, hence the few
   // extra cycles after the last result has come out.
   task automatic drain_block();
      req_tvalid <= 1'b0;
      while (awaited_maxima.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_register(input logic [CSR_INDEX_BITS-1:0] idx,
                                 input logic [CSR_DATA_BITS-1:0] value);
      drain_block();
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      if (idx == CSR_IMAGE_WIDTH) cfg_width = value[IMAGE_WIDTH_BITS-1:0];
      else cfg_height = value[IMAGE_HEIGHT_BITS-1:0];
   endtask

   initial begin
      int         phase_no;
      int         pick;
      int         which;
      int         old_w;
      int         new_w;
      int         new_h;
      int         w_val;
      int         h_val;
      int         count;
      bit         fill_phase;
      bit         width_first;
      bit         restart;
      logic       first;
      logic [7:0] pix;

      foreach (line_max[i]) line_max[i] = '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Directed table first.
      foreach (opening[i]) begin
         case (opening[i].kind)
            SEND_PIXEL: begin
               offer_pixel(opening[i].value[7:0], opening[i].first, opening[i].typed,
                           opening[i].typed_emit,
                           rsp_entry_type'({opening[i].typed_pixel, opening[i].typed_row_end,
                                            opening[i].typed_frame_end}));
            end
            SET_WIDTH: begin
               write_register(CSR_IMAGE_WIDTH, opening[i].value);
            end
            default: begin
               write_register(CSR_IMAGE_HEIGHT, opening[i].value);
            end
         endcase
      end

      // Random phases. Each one starts from an idle block, may change one or
      // both sizes, and then streams mostly whole frames of random pixels.
      phase_no = 0;
      while (pixels_accepted < ITEM_TARGET) begin
         old_w      = fit_size(int'(cfg_width), WIDTH_CAP);
         fill_phase = (phase_no % 25 == 2);
         pick       = $urandom_range(0, 11);
         if (fill_phase) begin
            // Narrow single-row frames give a result every pixel or two, so
            // the output queue fills quickly while the receiver holds off.
            w_val = $urandom_range(1, 2);
            h_val = 1;
         end else if (pick == 0) begin
            w_val = $urandom_range(0, 1) ? WIDTH_CAP : $urandom_range(200, 511);
            h_val = $urandom_range(0, 1) ? HEIGHT_CAP : $urandom_range(0, 2047);
         end else if (pick == 1) begin
            w_val = $urandom_range(0, 2);
            h_val = $urandom_range(0, 3);
         end else begin
            w_val = $urandom_range(1, 14);
            h_val = $urandom_range(1, 12);
         end
         // Width only, height only, both, or neither (a plain pause).
         which       = fill_phase ? 2 : $urandom_range(0, 3);
         width_first = 1'($urandom_range(0, 1));
         // The upper data bits are not part of the width and must be ignored.
         w_val = w_val | ($urandom_range(0, 3) << IMAGE_WIDTH_BITS);
         if ((which == 0 || which == 2) && width_first)
            write_register(CSR_IMAGE_WIDTH, CSR_DATA_BITS'(w_val));
         if (which == 1 || which == 2)
            write_register(CSR_IMAGE_HEIGHT, CSR_DATA_BITS'(h_val));
         if ((which == 0 || which == 2) && !width_first)
            write_register(CSR_IMAGE_WIDTH, CSR_DATA_BITS'(w_val));
         if (which == 3) drain_block();

         new_w = fit_size(int'(cfg_width), WIDTH_CAP);
         new_h = fit_size(int'(cfg_height), HEIGHT_CAP);
         // A wider image part-way through a frame would read line store
         // entries that were never filled, so such a phase starts a new frame.
         restart = (new_w > old_w) || ($urandom_range(0, 1) != 0);
         if (fill_phase) count = 48;
         else if (new_w * new_h <= 200)
            count = new_w * new_h * $urandom_range(1, 3)
                    + (($urandom_range(0, 2) == 0) ? $urandom_range(1, 2 * new_w) : 0);
         else count = $urandom_range(150, 450);
         // Keep the total close to the target.
         if (count > ITEM_TARGET - pixels_accepted) count = ITEM_TARGET - pixels_accepted;
         if (fill_phase) stall_cue <= ~stall_cue;

         for (int n = 0; n < count; n++) begin
            if (n == 0 && restart) first = 1'b1;
            else if (col_pos == 0 && row_pos == 0) first = 1'($urandom_range(0, 1));
            else first = ($urandom_range(0, 59) == 0);  // a frame cut short
            pick = $urandom_range(0, 9);
            if (pick == 0) pix = 8'h00;
            else if (pick == 1) pix = 8'hFF;
            else pix = 8'($urandom_range(0, 255));
            offer_pixel(pix, first, 1'b0, 1'b0, '0);
         end
         phase_no++;
      end

      // Let the last results out, then give a stray result time to appear.
      req_tvalid <= 1'b0;
      while (awaited_maxima.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && awaited_maxima.size() == 0) begin
         $display("max_pool_3x3_stride2_u8_top_test: done, clean");
      end else begin
         $display("max_pool_3x3_stride2_u8_top_test: done, errors");
      end
      $finish;
   end

   // ----------------------------------------------------------------------
   // Receiver side
   // ----------------------------------------------------------------------
   // Ready is randomised at each edge, except during the calm stretch and
   // during a long hold-off, which this process counts out itself.
   always @(posedge clock) begin
      int   hold_left;
      logic cue_seen;
      if (reset) begin
         rsp_tready <= 1'b0;
         hold_left  = 0;
         cue_seen   = stall_cue;
      end else begin
         if (stall_cue != cue_seen) begin
            cue_seen  = stall_cue;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= quiet || ($urandom_range(0, 99) >= 34);
         end
      end
   end

   function automatic void compare_field(input string what, input logic [7:0] want,
                                         input logic [7:0] got);
      if (want !== got) begin
         mismatch_count++;
         if (mismatch_count <= REPORT_LIMIT)
            $display("%0t ns: %s expected %0d, got %0d", $time, what, want, got);
      end
   endfunction

   // Outputs only move at rising edges, so the falling edge before a handshake
   // sees exactly what that handshake will carry. Checking here keeps the
   // queue pops well apart from the pushes the sender makes at rising edges.
   always @(negedge clock) begin
      rsp_entry_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         maxima_received++;
         if (awaited_maxima.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= REPORT_LIMIT)
               $display("%0t ns: result expected none, got %0d", $time, rsp_tdata);
         end else begin
            want = awaited_maxima.pop_front();
            compare_field("pixel_out", want.pixel, rsp_tdata);
            compare_field("row_end", {7'd0, want.row_end}, {7'd0, rsp_tlast});
            compare_field("frame_end", {7'd0, want.frame_end}, {7'd0, rsp_tuser});
         end
      end
   end

   // Guard against a hang: far longer than the slowest correct run needs.
   initial begin
      #(RUN_LIMIT_NS);
      $display("max_pool_3x3_stride2_u8_top_test: done, errors");
      $finish;
   end

endmodule
